[rtl/euler_view_matrix_defines.svh]
// ---------------------------------------------------------------------------
// euler_view_matrix assertion macros
// Shared concurrent assertion forms, clocked on i_clk, held off in reset.
// ---------------------------------------------------------------------------
`ifndef EULER_VIEW_MATRIX_DEFINES_SVH
`define EULER_VIEW_MATRIX_DEFINES_SVH

// same-cycle implication
`define EVM_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define EVM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/evm_pkg.sv]
// ---------------------------------------------------------------------------
// evm_pkg
// Constants, stage types and rounding helpers for the view matrix pipeline.
// ---------------------------------------------------------------------------
package evm_pkg;

    localparam int ANGLE_BITS_DEF      = 16;
    localparam int ENTRY_FRAC_BITS_DEF = 14;

    // pi in Q32
    localparam logic [63:0] PI_Q32 = 64'd13493037705;

    // reciprocal shift for the factorial divides (30-bit numerator, divisor < 256)
    localparam int DIV_SHIFT = 38;
    localparam int NUM_TERMS = 6;

    // ceil(2^38 / d) for the sine and cosine series divisors
    localparam logic [37:0] SDIV_M [NUM_TERMS] = '{
        38'((( 64'd1 << 38) + 64'd5)   / 64'd6),
        38'((( 64'd1 << 38) + 64'd19)  / 64'd20),
        38'((( 64'd1 << 38) + 64'd41)  / 64'd42),
        38'((( 64'd1 << 38) + 64'd71)  / 64'd72),
        38'((( 64'd1 << 38) + 64'd109) / 64'd110),
        38'((( 64'd1 << 38) + 64'd155) / 64'd156)
    };
    localparam logic [37:0] CDIV_M [NUM_TERMS] = '{
        38'((( 64'd1 << 38) + 64'd1)   / 64'd2),
        38'((( 64'd1 << 38) + 64'd11)  / 64'd12),
        38'((( 64'd1 << 38) + 64'd29)  / 64'd30),
        38'((( 64'd1 << 38) + 64'd55)  / 64'd56),
        38'((( 64'd1 << 38) + 64'd89)  / 64'd90),
        38'((( 64'd1 << 38) + 64'd131) / 64'd132)
    };

    // product stage of one series step
    typedef struct packed {
        logic [1:0]         quad;
        logic               swap;
        logic [29:0]        x2;
        logic signed [31:0] ss;
        logic signed [31:0] cc;
        logic [59:0]        ps;
        logic [59:0]        pc;
    } t_pst;

    // reciprocal stage of one series step
    typedef struct packed {
        logic [1:0]         quad;
        logic               swap;
        logic [29:0]        x2;
        logic signed [31:0] ss;
        logic signed [31:0] cc;
        logic [66:0]        qs;
        logic [66:0]        qc;
    } t_qst;

    // round half away from zero, then shift right
    function automatic logic signed [63:0] evm_rnd(input logic signed [63:0] v,
                                                   input int sh);
        logic        neg;
        logic [63:0] m;
        if (sh == 0) begin
            return v;
        end
        neg = v[63];
        m   = neg ? 64'(-v) : 64'(v);
        m   = (m + (64'd1 << (sh - 1))) >> sh;
        return neg ? -$signed(m) : $signed(m);
    endfunction

    // round from Q30 and saturate to a 16-bit entry
    function automatic logic signed [15:0] evm_ent(input logic signed [63:0] v,
                                                   input int sh);
        logic signed [63:0] r;
        r = evm_rnd(v, sh);
        if (r < -64'sd32768) begin
            return 16'sh8000;
        end else if (r > 64'sd32767) begin
            return 16'sh7fff;
        end
        return 16'(r);
    endfunction

endpackage

[rtl/euler_view_matrix.sv]
// ---------------------------------------------------------------------------
// euler_view_matrix
// Euler-angle view matrix: rotation entries and saturated translation.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream carries one camera setup per transfer: position (Q16.16)
//   and three turn-fraction angles. Master stream returns the nine rotation
//   entries (Q2.14 at default) and the three translation terms (Q16.16).
//   The pipeline has 21 register stages; o_m_axis_tvalid rises once a
//   transfer has passed all of them. Throughput is one transfer per cycle
//   unless the receiver stalls; every stage is registered and the
//   sine/cosine series runs as six unrolled product/reciprocal step pairs.
//   Reset (synchronous, active low) empties the pipeline; payload is kept.
//   When the receiver stalls with a result waiting, the whole pipeline
//   holds and o_s_axis_tready drops; nothing is lost or repeated.
// ---------------------------------------------------------------------------
module euler_view_matrix
    import evm_pkg::*;
#(
    parameter int ANGLE_BITS      = ANGLE_BITS_DEF,
    parameter int ENTRY_FRAC_BITS = ENTRY_FRAC_BITS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // cam_x, cam_y, cam_z, angle_x, angle_y, angle_z
    input  logic [143:0] i_s_axis_tdata,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // entry_0, 1, 2, 4, 5, 6, 8, 9, 10, trans_x, trans_y, trans_z
    output logic [239:0] o_m_axis_tdata
);

    localparam int NST   = 21;
    localparam int CAMD  = 19;
    localparam int ESH   = 30 - ENTRY_FRAC_BITS;

    logic           en;
    logic [NST:1]   r_vld;

    // camera position delay line
    logic [95:0]    r_cam [1:CAMD];

    // reduction, scaling and square
    logic [1:0]     r1_quad [3];
    logic           r1_swap [3];
    logic [29:0]    r1_phi  [3];
    logic [1:0]     r2_quad [3];
    logic           r2_swap [3];
    logic [29:0]    r2_x    [3];
    logic [1:0]     r3_quad [3];
    logic           r3_swap [3];
    logic [29:0]    r3_x    [3];
    logic [29:0]    r3_x2   [3];

    // series steps
    t_pst           r_p [3][NUM_TERMS];
    t_pst           n_p [3][NUM_TERMS];
    t_qst           r_q [3][NUM_TERMS];
    t_qst           n_q [3][NUM_TERMS];

    logic signed [31:0] r_sin [3];
    logic signed [31:0] r_cos [3];
    logic signed [31:0] n_sin [3];
    logic signed [31:0] n_cos [3];

    // combination stages
    logic signed [63:0] r17_sxsy, r17_cxsy, r17_cycz, r17_cysz, r17_sxcy;
    logic signed [63:0] r17_cxcy, r17_cxsz, r17_cxcz, r17_sxsz, r17_sxcz;
    logic signed [31:0] r17_sy, r17_sz, r17_cz;
    logic signed [63:0] r18_a, r18_b, r18_c, r18_d;
    logic signed [33:0] r18_cycz, r18_cysz, r18_sxcy, r18_cxcy;
    logic signed [33:0] r18_cxsz, r18_cxcz, r18_sxsz, r18_sxcz;
    logic signed [31:0] r18_sy;
    logic signed [15:0] r19_e [9];
    logic signed [47:0] r20_p [9];
    logic signed [15:0] r20_e [9];
    logic [239:0]       r_out;

    // advance unless a result waits on a stalled receiver
    assign en              = !r_vld[NST] || i_m_axis_tready;
    assign o_s_axis_tready = en;
    assign o_m_axis_tvalid = r_vld[NST];
    assign o_m_axis_tdata  = r_out;

    // valid bits travel with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NST-1:1], i_s_axis_tvalid};
        end
    end

    // front end: reduce, scale to radians, square
    always_ff @(posedge i_clk) begin
        logic [31:0] t;
        logic [29:0] r;
        if (en) begin
            r_cam[1] <= i_s_axis_tdata[95:0];
            for (int k = 2; k <= CAMD; k++) begin
                r_cam[k] <= r_cam[k-1];
            end
            for (int l = 0; l < 3; l++) begin
                t          = 32'(i_s_axis_tdata[96 + 16*l +: 16]) << (32 - ANGLE_BITS);
                r          = t[29:0];
                r1_quad[l] <= t[31:30];
                r1_swap[l] <= (r > 30'h2000_0000);
                r1_phi[l]  <= (r > 30'h2000_0000) ?
                              30'(31'h4000_0000 - {1'b0, r}) : r;
                r2_quad[l] <= r1_quad[l];
                r2_swap[l] <= r1_swap[l];
                r2_x[l]    <= 30'((64'(r1_phi[l]) * PI_Q32 + (64'd1 << 32)) >> 33);
                r3_quad[l] <= r2_quad[l];
                r3_swap[l] <= r2_swap[l];
                r3_x[l]    <= r2_x[l];
                r3_x2[l]   <= 30'((60'(r2_x[l]) * 60'(r2_x[l]) + (60'd1 << 29)) >> 30);
            end
        end
    end

    // series steps: multiply by x^2, then divide by a reciprocal multiply
    always_comb begin
        logic [29:0] trs;
        logic [29:0] trc;
        logic [29:0] ts;
        logic [29:0] tc;
        for (int l = 0; l < 3; l++) begin
            for (int j = 0; j < NUM_TERMS; j++) begin
                trs = '0;
                trc = '0;
                if (j == 0) begin
                    n_p[l][j].quad = r3_quad[l];
                    n_p[l][j].swap = r3_swap[l];
                    n_p[l][j].x2   = r3_x2[l];
                    n_p[l][j].ss   = $signed({2'b00, r3_x[l]});
                    n_p[l][j].cc   = 32'sh4000_0000;
                    n_p[l][j].ps   = 60'(r3_x[l]) * 60'(r3_x2[l]);
                    n_p[l][j].pc   = {r3_x2[l], 30'd0};
                end else begin
                    trs = 30'(r_q[l][j-1].qs >> DIV_SHIFT);
                    trc = 30'(r_q[l][j-1].qc >> DIV_SHIFT);
                    n_p[l][j].quad = r_q[l][j-1].quad;
                    n_p[l][j].swap = r_q[l][j-1].swap;
                    n_p[l][j].x2   = r_q[l][j-1].x2;
                    if ((j - 1) % 2 == 1) begin
                        n_p[l][j].ss = r_q[l][j-1].ss + $signed({2'b00, trs});
                        n_p[l][j].cc = r_q[l][j-1].cc + $signed({2'b00, trc});
                    end else begin
                        n_p[l][j].ss = r_q[l][j-1].ss - $signed({2'b00, trs});
                        n_p[l][j].cc = r_q[l][j-1].cc - $signed({2'b00, trc});
                    end
                    n_p[l][j].ps = 60'(trs) * 60'(r_q[l][j-1].x2);
                    n_p[l][j].pc = 60'(trc) * 60'(r_q[l][j-1].x2);
                end
                ts = 30'((r_p[l][j].ps + (60'd1 << 29)) >> 30);
                tc = 30'((r_p[l][j].pc + (60'd1 << 29)) >> 30);
                n_q[l][j].quad = r_p[l][j].quad;
                n_q[l][j].swap = r_p[l][j].swap;
                n_q[l][j].x2   = r_p[l][j].x2;
                n_q[l][j].ss   = r_p[l][j].ss;
                n_q[l][j].cc   = r_p[l][j].cc;
                n_q[l][j].qs   = 67'(ts) * 67'(SDIV_M[j]);
                n_q[l][j].qc   = 67'(tc) * 67'(CDIV_M[j]);
            end
        end
    end

    // last term, then fold into the quadrant
    always_comb begin
        logic signed [31:0] ss;
        logic signed [31:0] cc;
        logic signed [31:0] a;
        logic signed [31:0] b;
        for (int l = 0; l < 3; l++) begin
            ss = r_q[l][NUM_TERMS-1].ss +
                 $signed({2'b00, 30'(r_q[l][NUM_TERMS-1].qs >> DIV_SHIFT)});
            cc = r_q[l][NUM_TERMS-1].cc +
                 $signed({2'b00, 30'(r_q[l][NUM_TERMS-1].qc >> DIV_SHIFT)});
            a  = r_q[l][NUM_TERMS-1].swap ? cc : ss;
            b  = r_q[l][NUM_TERMS-1].swap ? ss : cc;
            case (r_q[l][NUM_TERMS-1].quad)
                2'd0: begin
                    n_sin[l] = a;
                    n_cos[l] = b;
                end
                2'd1: begin
                    n_sin[l] = b;
                    n_cos[l] = -a;
                end
                2'd2: begin
                    n_sin[l] = -a;
                    n_cos[l] = -b;
                end
                default: begin
                    n_sin[l] = -b;
                    n_cos[l] = a;
                end
            endcase
        end
    end

    // hold the series registers
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p   <= n_p;
            r_q   <= n_q;
            r_sin <= n_sin;
            r_cos <= n_cos;
        end
    end

    // combine the rotation terms
    always_ff @(posedge i_clk) begin
        logic signed [33:0] sxsy;
        logic signed [33:0] cxsy;
        if (en) begin
            // raw Q60 products
            r17_sxsy <= 64'(r_sin[0] * r_sin[1]);
            r17_cxsy <= 64'(r_cos[0] * r_sin[1]);
            r17_cycz <= 64'(r_cos[1] * r_cos[2]);
            r17_cysz <= 64'(r_cos[1] * r_sin[2]);
            r17_sxcy <= 64'(r_sin[0] * r_cos[1]);
            r17_cxcy <= 64'(r_cos[0] * r_cos[1]);
            r17_cxsz <= 64'(r_cos[0] * r_sin[2]);
            r17_cxcz <= 64'(r_cos[0] * r_cos[2]);
            r17_sxsz <= 64'(r_sin[0] * r_sin[2]);
            r17_sxcz <= 64'(r_sin[0] * r_cos[2]);
            r17_sy   <= r_sin[1];
            r17_sz   <= r_sin[2];
            r17_cz   <= r_cos[2];

            // round to Q30, second-level products
            sxsy     = 34'(evm_rnd(r17_sxsy, 30));
            cxsy     = 34'(evm_rnd(r17_cxsy, 30));
            r18_a    <= 64'(sxsy * r17_cz);
            r18_b    <= 64'(sxsy * r17_sz);
            r18_c    <= 64'(cxsy * r17_cz);
            r18_d    <= 64'(cxsy * r17_sz);
            r18_cycz <= 34'(evm_rnd(r17_cycz, 30));
            r18_cysz <= 34'(evm_rnd(r17_cysz, 30));
            r18_sxcy <= 34'(evm_rnd(r17_sxcy, 30));
            r18_cxcy <= 34'(evm_rnd(r17_cxcy, 30));
            r18_cxsz <= 34'(evm_rnd(r17_cxsz, 30));
            r18_cxcz <= 34'(evm_rnd(r17_cxcz, 30));
            r18_sxsz <= 34'(evm_rnd(r17_sxsz, 30));
            r18_sxcz <= 34'(evm_rnd(r17_sxcz, 30));
            r18_sy   <= r17_sy;

            // entries
            r19_e[0] <= evm_ent(64'(r18_cycz), ESH);
            r19_e[1] <= evm_ent(64'(r18_cysz), ESH);
            r19_e[2] <= evm_ent(-64'(r18_sy), ESH);
            r19_e[3] <= evm_ent(evm_rnd(r18_a, 30) - 64'(r18_cxsz), ESH);
            r19_e[4] <= evm_ent(evm_rnd(r18_b, 30) + 64'(r18_cxcz), ESH);
            r19_e[5] <= evm_ent(64'(r18_sxcy), ESH);
            r19_e[6] <= evm_ent(evm_rnd(r18_c, 30) + 64'(r18_sxsz), ESH);
            r19_e[7] <= evm_ent(evm_rnd(r18_d, 30) - 64'(r18_sxcz), ESH);
            r19_e[8] <= evm_ent(64'(r18_cxcy), ESH);
        end
    end

    // translation products and output
    always_ff @(posedge i_clk) begin
        logic signed [63:0] sum;
        logic signed [63:0] v;
        logic [239:0]       n_out;
        if (en) begin
            for (int i = 0; i < 9; i++) begin
                r20_p[i] <= 48'(r19_e[i] * $signed(r_cam[CAMD][32*(i/3) +: 32]));
                r20_e[i] <= r19_e[i];
            end
            for (int c = 0; c < 3; c++) begin
                sum = 64'(r20_p[c]) + 64'(r20_p[c+3]) + 64'(r20_p[c+6]);
                v   = -evm_rnd(sum, ENTRY_FRAC_BITS);
                if (v < -64'sd2147483648) begin
                    n_out[144 + 32*c +: 32] = 32'h8000_0000;
                end else if (v > 64'sd2147483647) begin
                    n_out[144 + 32*c +: 32] = 32'h7fff_ffff;
                end else begin
                    n_out[144 + 32*c +: 32] = 32'(v);
                end
            end
            for (int i = 0; i < 9; i++) begin
                n_out[16*i +: 16] = r20_e[i];
            end
            r_out <= n_out;
        end
    end

`include "euler_view_matrix_defines.svh"

    `EVM_ASSERT_NEXT(a_in_enters, i_s_axis_tvalid && o_s_axis_tready, r_vld[1], "accepted transfer did not enter the pipeline")
    `EVM_ASSERT_NEXT(a_stall_holds, !en, $stable(r_vld), "pipeline moved while stalled")
    `EVM_ASSERT_NEXT(a_result_lands, en && r_vld[NST-1], o_m_axis_tvalid, "result lost before output")

endmodule

[bench/tb_euler_view_matrix.sv]
// ---------------------------------------------------------------------------
// tb_euler_view_matrix
// Streams camera setups into the view matrix block and checks every result
// against a bit-accurate fixed-point predictor, under random idling on both
// sides, a long receiver hold-off and a full drain pause.
// ---------------------------------------------------------------------------
module tb_euler_view_matrix;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ANG_BITS  = 16;
    localparam int FRAC_BITS = 14;
    localparam int N_RANDOM  = 1430;
    localparam int LATENCY   = 21;
    localparam longint MAX_CYCLES = 400000;

    typedef struct packed {
        logic signed [31:0] trans_z;
        logic signed [31:0] trans_y;
        logic signed [31:0] trans_x;
        logic signed [15:0] e10;
        logic signed [15:0] e9;
        logic signed [15:0] e8;
        logic signed [15:0] e6;
        logic signed [15:0] e5;
        logic signed [15:0] e4;
        logic signed [15:0] e2;
        logic signed [15:0] e1;
        logic signed [15:0] e0;
    } t_view;

    typedef struct packed {
        logic [15:0]        ang_z;
        logic [15:0]        ang_y;
        logic [15:0]        ang_x;
        logic signed [31:0] cam_z;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_x;
    } t_setup;

    // round half away from zero, then shift right
    function automatic longint rnd_away(longint v, int sh);
        logic        neg;
        logic [63:0] m;
        if (sh == 0) begin
            return v;
        end
        neg = v < 0;
        m   = neg ? 64'(-v) : 64'(v);
        m   = (m + (64'd1 << (sh - 1))) >> sh;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint mulq(longint a, longint b);
        return rnd_away(a * b, 30);
    endfunction

    // Taylor series sine/cosine of a 32-bit turn count, Q30
    function automatic void sincos(input logic [31:0] t, output longint s,
                                   output longint c);
        int          sd [6];
        int          cd [6];
        logic [1:0]  quad;
        logic [29:0] r;
        logic        swp;
        logic [63:0] phi, x, x2, term;
        longint      ss, cc, a, b;
        sd = '{6, 20, 42, 72, 110, 156};
        cd = '{2, 12, 30, 56, 90, 132};
        quad = t[31:30];
        r    = t[29:0];
        swp  = r > 30'h2000_0000;
        phi  = swp ? 64'(32'h4000_0000 - r) : 64'(r);
        x    = (phi * 64'd13493037705 + (64'd1 << 32)) >> 33;
        x2   = (x * x + (64'd1 << 29)) >> 30;
        term = x;
        ss   = longint'(x);
        for (int k = 0; k < 6; k++) begin
            term = ((term * x2 + (64'd1 << 29)) >> 30) / sd[k];
            ss   = (k & 1) ? ss + longint'(term) : ss - longint'(term);
        end
        term = 64'd1 << 30;
        cc   = 64'sd1 << 30;
        for (int k = 0; k < 6; k++) begin
            term = ((term * x2 + (64'd1 << 29)) >> 30) / cd[k];
            cc   = (k & 1) ? cc + longint'(term) : cc - longint'(term);
        end
        if (swp) begin
            a = cc; b = ss;
        end else begin
            a = ss; b = cc;
        end
        case (quad)
            2'd0: begin s = a;  c = b;  end
            2'd1: begin s = b;  c = -a; end
            2'd2: begin s = -a; c = -b; end
            default: begin s = -b; c = a; end
        endcase
    endfunction

    function automatic longint q30_entry(longint v);
        longint r;
        r = rnd_away(v, 30 - FRAC_BITS);
        return r < -32768 ? -32768 : (r > 32767 ? 32767 : r);
    endfunction

    function automatic logic [31:0] translate(longint a, longint b, longint c,
                                              longint px, longint py, longint pz);
        longint v;
        v = -rnd_away(a * px + b * py + c * pz, FRAC_BITS);
        if (v < -64'sd2147483648) begin
            v = -64'sd2147483648;
        end else if (v > 64'sd2147483647) begin
            v = 64'sd2147483647;
        end
        return v[31:0];
    endfunction

    // compute the expected view matrix of one camera setup
    function automatic t_view view_of(t_setup st);
        longint sx, cx, sy, cy, sz, cz, sxsy, cxsy;
        longint e [9];
        longint px, py, pz;
        t_view  v;
        sincos({st.ang_x[ANG_BITS-1:0], {(32-ANG_BITS){1'b0}}}, sx, cx);
        sincos({st.ang_y[ANG_BITS-1:0], {(32-ANG_BITS){1'b0}}}, sy, cy);
        sincos({st.ang_z[ANG_BITS-1:0], {(32-ANG_BITS){1'b0}}}, sz, cz);
        sxsy = mulq(sx, sy);
        cxsy = mulq(cx, sy);
        e[0] = q30_entry(mulq(cy, cz));
        e[1] = q30_entry(mulq(cy, sz));
        e[2] = q30_entry(-sy);
        e[3] = q30_entry(mulq(sxsy, cz) - mulq(cx, sz));
        e[4] = q30_entry(mulq(sxsy, sz) + mulq(cx, cz));
        e[5] = q30_entry(mulq(sx, cy));
        e[6] = q30_entry(mulq(cxsy, cz) + mulq(sx, sz));
        e[7] = q30_entry(mulq(cxsy, sz) - mulq(sx, cz));
        e[8] = q30_entry(mulq(cx, cy));
        px = longint'(st.cam_x); py = longint'(st.cam_y); pz = longint'(st.cam_z);
        v.e0 = 16'(e[0]); v.e1 = 16'(e[1]); v.e2 = 16'(e[2]);
        v.e4 = 16'(e[3]); v.e5 = 16'(e[4]); v.e6 = 16'(e[5]);
        v.e8 = 16'(e[6]); v.e9 = 16'(e[7]); v.e10 = 16'(e[8]);
        v.trans_x = translate(e[0], e[3], e[6], px, py, pz);
        v.trans_y = translate(e[1], e[4], e[7], px, py, pz);
        v.trans_z = translate(e[2], e[5], e[8], px, py, pz);
        return v;
    endfunction

    class view_scoreboard;
        t_view pending[$];
        int    errors;

        function void note_setup(t_setup st);
            pending = {pending, view_of(st)};
        endfunction

        function void cmp16(string nm, logic [15:0] exp_v, logic [15:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0d, got %0d", nm, $signed(exp_v), $signed(act_v));
                errors++;
            end
        endfunction

        function void cmp32(string nm, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %0d, got %0d", nm, $signed(exp_v), $signed(act_v));
                errors++;
            end
        endfunction

        function void check_view(t_view got);
            t_view w;
            if (pending.size() == 0) begin
                $error("result with no setup outstanding");
                errors++;
                return;
            end
            w = pending.pop_front();
            cmp16("entry_0", w.e0, got.e0);
            cmp16("entry_1", w.e1, got.e1);
            cmp16("entry_2", w.e2, got.e2);
            cmp16("entry_4", w.e4, got.e4);
            cmp16("entry_5", w.e5, got.e5);
            cmp16("entry_6", w.e6, got.e6);
            cmp16("entry_8", w.e8, got.e8);
            cmp16("entry_9", w.e9, got.e9);
            cmp16("entry_10", w.e10, got.e10);
            cmp32("trans_x", w.trans_x, got.trans_x);
            cmp32("trans_y", w.trans_y, got.trans_y);
            cmp32("trans_z", w.trans_z, got.trans_z);
        endfunction
    endclass

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [143:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [239:0] m_tdata;

    view_scoreboard sb = new();
    bit     idle_free;      // stretch with no idling
    bit     rx_hold;        // long receiver hold-off
    longint cycles = 0;

    euler_view_matrix u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        // cam_x, cam_y, cam_z, angle_x, angle_y, angle_z
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        // entry_0, 1, 2, 4, 5, 6, 8, 9, 10, trans_x, trans_y, trans_z
        .o_m_axis_tdata  (m_tdata)
    );

    always #1 i_clk = ~i_clk;

    // guard against a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("** euler_view_matrix: FAILED **");
            $finish;
        end
    end

    // check each result transfer; stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            sb.check_view(t_view'(m_tdata));
        end
        m_tready <= !rx_hold && (idle_free || $urandom_range(99) >= 15);
    end

    // send one setup, idling at random beforehand
    task automatic send_setup(t_setup st);
        while (!idle_free && $urandom_range(99) < 15) begin
            s_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= st;
        do @(posedge i_clk); while (!s_tready);
        sb.note_setup(st);
    endtask

    function automatic logic [31:0] rand_cam();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'($signed($urandom_range(2000000)) - 1000000);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [15:0] rand_angle();
        logic [15:0] q;
        q = 16'($urandom_range(3)) << 14;
        case ($urandom_range(5))
            0: return q;
            1: return q + 16'h2000 + 16'($signed($urandom_range(4)) - 2);
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        t_setup st;
        idle_free = 0;
        rx_hold = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: quadrant points, octant boundaries, saturating positions
        for (int i = 0; i < 20; i++) begin
            st.ang_x = 16'(i * 16'h2000);
            st.ang_y = 16'(i * 16'h4000 + 16'h2000 * (i / 4));
            st.ang_z = 16'(16'hffff - i * 16'h1000);
            st.cam_x = (i & 1) ? 32'h7fff_ffff : 32'h8000_0000;
            st.cam_y = (i & 2) ? 32'h7fff_ffff : 32'h8000_0000;
            st.cam_z = (i & 4) ? 32'h8000_0000 : 32'h0001_0000;
            send_setup(st);
        end
        st = '0;
        send_setup(st);
        st = '1;
        send_setup(st);
        st.ang_x = 16'h2001; st.ang_y = 16'h1fff; st.ang_z = 16'h6000;
        send_setup(st);

        // random setups with a free stretch, a long hold-off and a drain pause
        for (int n = 0; n < N_RANDOM; n++) begin
            idle_free = (n >= 300 && n < 500);
            if (n == 700) begin
                rx_hold = 1;
                fork
                    begin
                        repeat (200) @(posedge i_clk);
                        rx_hold = 0;
                    end
                join_none
            end
            if (n == 1000) begin
                s_tvalid <= 1'b0;
                while (sb.pending.size() != 0) @(posedge i_clk);
            end
            st.cam_x = rand_cam();
            st.cam_y = rand_cam();
            st.cam_z = rand_cam();
            st.ang_x = rand_angle();
            st.ang_y = rand_angle();
            st.ang_z = rand_angle();
            send_setup(st);
        end
        s_tvalid <= 1'b0;

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 10) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("** euler_view_matrix: PASSED **");
        end else begin
            $display("** euler_view_matrix: FAILED **");
        end
        $finish;
    end

endmodule
